/* rtl/sftd_pkg.sv */
// Shared types, constants and the CRC-8 helper for the sensor frame decoder.
`timescale 1ns / 1ps

package sftd_pkg;

  // Position of the next byte within a three-byte frame
  typedef enum logic [1:0] {
    POS_HIGH = 2'd0,
    POS_LOW  = 2'd1,
    POS_CRC  = 2'd2
  } byte_pos_e;

  // CRC-8, x^8+x^5+x^4+1, no reflection, no final xor
  localparam logic [7:0] CRC_POLY_LOW = 8'h31;

  // Low byte: bits [7:2] are data, bit 1 is the status flag
  localparam logic [7:0] LOW_DATA_MASK = 8'hFC;
  localparam int unsigned STATUS_BIT   = 1;

  // temperature = trunc((raw * 17572 - 307036160) / 6553600)
  localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
  localparam logic signed [31:0] TEMP_OFFSET = 32'sd307036160;

  // 6553600 = 2^18 * 25; divide by 25 as multiply by ceil(2^16/25)
  localparam int unsigned        DIV_SHIFT   = 18;
  localparam logic [11:0]        DIV25_RECIP = 12'd2622;
  localparam int unsigned        RECIP_SHIFT = 16;

  localparam logic signed [7:0]  TEMP_MAX = 8'sd127;
  localparam logic signed [7:0]  TEMP_MIN = -8'sd128;

  // Per-result side information carried along the pipeline
  typedef struct packed {
    logic [15:0] raw;
    logic        status_err;
    logic        crc_err;
  } frame_info_t;

  // One byte through the CRC-8 shift register
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY_LOW;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* rtl/sftd_temp_conv.sv */
// Scaled reading to degrees Celsius: truncating divide by 6553600, saturation and status override.
`timescale 1ns / 1ps

module sftd_temp_conv (
  input  logic signed [31:0] num_i,         // raw * scale - offset
  input  logic               status_err_i,
  output logic signed [7:0]  temperature_o
);

  logic        neg;
  logic [30:0] mag;
  logic [12:0] coarse;
  logic [24:0] prod;
  logic [8:0]  quot;

  // Magnitude, then drop the power-of-two part of the divisor
  assign neg    = num_i[31];
  assign mag    = neg ? 31'(-num_i) : num_i[30:0];
  assign coarse = mag[30:sftd_pkg::DIV_SHIFT];

  // Divide by 25 via reciprocal; exact for coarse below 4681
  assign prod = 25'(coarse * sftd_pkg::DIV25_RECIP);
  assign quot = prod[24:sftd_pkg::RECIP_SHIFT];

  // Status override, sign restore and saturation
  always_comb begin
    priority if (status_err_i) begin
      temperature_o = sftd_pkg::TEMP_MIN;
    end else if (neg) begin
      temperature_o = 8'(9'd0 - quot);
    end else if (quot > 9'd127) begin
      temperature_o = sftd_pkg::TEMP_MAX;
    end else begin
      temperature_o = quot[7:0];
    end
  end

endmodule

/* rtl/sensor_frame_temperature_decoder.sv */
// Top level: three-byte sensor frame decoder with CRC check and temperature conversion.
//
// Input stream: one frame byte per item on s_axis; s_axis_tuser marks the
// first byte of a frame and restarts position and CRC. After the high byte,
// the low byte (bit 1 is the sensor status) and the checksum byte, one
// result leaves on m_axis; bytes one and two give no result. A frame that is
// restarted before its third byte is dropped without a result.
// Path: a checksum byte passes the input register, then the CRC/scale register,
// then the divide/saturate output register, where its result becomes valid.
// Throughput: one byte per cycle while the output is not stalled; each of the three
// registers is a full stage with its own valid bit, so bubbles are squeezed out.
// Stall: while m_axis_tready is low the result holds on the port; bytes keep
// being taken until the three stages are full, then s_axis_tready drops.
// Reset: all stages empty, byte position, running CRC and data bytes zero.
`timescale 1ns / 1ps

module sensor_frame_temperature_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] temperature, [23:8] raw_reading
  output logic [1:0]  m_axis_tuser    // [0] status_error, [1] crc_error
);

  // Stage handshake
  logic out_ready, b_ready, a_ready;
  logic a_move;

  // Input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_start_q;

  // Frame state
  sftd_pkg::byte_pos_e pos_q, pos_d, pos_cur;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          high_q, high_d;
  logic [7:0]          low_q, low_d;
  logic                is_last;

  // Conversion stage
  logic                  b_valid_q;
  logic signed [31:0]    b_num_q, b_num_d;
  sftd_pkg::frame_info_t b_info_q, b_info_d;
  logic [30:0]           scaled;

  // Output register
  logic                  out_valid_q;
  logic signed [7:0]     out_temp_q, temp_d;
  sftd_pkg::frame_info_t out_info_q;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign b_ready       = !b_valid_q || out_ready;
  assign a_ready       = !a_valid_q || b_ready;
  assign s_axis_tready = a_ready;
  assign a_move        = a_valid_q && b_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && s_axis_tvalid) begin
      a_byte_q  <= s_axis_tdata;
      a_start_q <= s_axis_tuser;
    end
  end

  // Frame position, running CRC and data byte capture
  always_comb begin
    pos_cur = a_start_q ? sftd_pkg::POS_HIGH : pos_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    high_d  = high_q;
    low_d   = low_q;
    is_last = 1'b0;
    unique case (pos_cur)
      sftd_pkg::POS_LOW: begin
        low_d = a_byte_q;
        crc_d = sftd_pkg::crc8_update(crc_q, a_byte_q);
        pos_d = sftd_pkg::POS_CRC;
      end
      sftd_pkg::POS_CRC: begin
        is_last = 1'b1;
        crc_d   = '0;
        pos_d   = sftd_pkg::POS_HIGH;
      end
      default: begin
        high_d = a_byte_q;
        crc_d  = sftd_pkg::crc8_update(8'h00, a_byte_q);
        pos_d  = sftd_pkg::POS_LOW;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= sftd_pkg::POS_HIGH;
      crc_q  <= '0;
      high_q <= '0;
      low_q  <= '0;
    end else if (a_move) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  // Raw reading, flags and scaled value for the frame's last byte
  always_comb begin
    b_info_d.raw        = {high_q, low_q & sftd_pkg::LOW_DATA_MASK};
    b_info_d.status_err = low_q[sftd_pkg::STATUS_BIT];
    b_info_d.crc_err    = !b_info_d.status_err && (crc_q != a_byte_q);
    scaled              = 31'(b_info_d.raw * sftd_pkg::TEMP_SCALE);
    b_num_d             = $signed({1'b0, scaled}) - sftd_pkg::TEMP_OFFSET;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q && is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move && is_last) begin
      b_num_q  <= b_num_d;
      b_info_q <= b_info_d;
    end
  end

  // Divide and saturate
  sftd_temp_conv u_temp_conv (
    .num_i         (b_num_q),
    .status_err_i  (b_info_q.status_err),
    .temperature_o (temp_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && b_valid_q) begin
      out_temp_q <= temp_d;
      out_info_q <= b_info_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_info_q.raw, out_temp_q};
  assign m_axis_tuser  = {out_info_q.crc_err, out_info_q.status_err};

endmodule

/* rtl/sftd_checker.sv */
// Port-level checks for the sensor frame decoder, bound to the top level.
`timescale 1ns / 1ps

module sftd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Status error forces -128 and clears the CRC flag
  a_status_override: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[7:0] == 8'h80 && !m_axis_tuser[1])
    else $error("status error result not overridden");

  // A real reading never reaches -128
  a_temp_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] != 8'h80)
    else $error("temperature below sensor range");

  // Status bits are masked out of the raw reading
  a_raw_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:8] == 2'b00)
    else $error("raw reading carries status bits");

endmodule

bind sensor_frame_temperature_decoder sftd_checker u_sftd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* verif/sensor_frame_temperature_decoder_tb.sv */
// Self-checking testbench for the sensor frame temperature decoder.
`timescale 1ns / 1ps

module sensor_frame_temperature_decoder_tb;

  // Exact integer form of the conversion: trunc((raw * gain - bias) / div)
  localparam longint TEMP_GAIN = 17572;
  localparam longint TEMP_BIAS = 307036160;
  localparam longint TEMP_DIV  = 6553600;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  // One decoded frame as it should leave the block
  typedef struct packed {
    logic signed [7:0] temp;
    logic [15:0]       raw;
    logic              status_err;
    logic              crc_err;
  } reading_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [7:0] temperature, [23:8] raw_reading
  logic [1:0]  m_axis_tuser;           // [0] status_error, [1] crc_error

  // Frame decoder state mirrored by the testbench
  logic [1:0]  frame_pos  = sftd_pkg::POS_HIGH;
  logic [7:0]  frame_crc  = 8'h00;
  logic [7:0]  frame_high = 8'h00;
  logic [7:0]  frame_low  = 8'h00;

  reading_t    pending_readings[$];
  int          errors       = 0;
  int          items_sent   = 0;
  int          idle_cycles  = 0;
  int          sink_stall   = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  sensor_frame_temperature_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Checksum: MSB-first shift register, no reflection, no final xor
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ sftd_pkg::CRC_POLY_LOW) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] frame_checksum(input logic [7:0] hi, input logic [7:0] lo);
    return crc8_next(crc8_next(8'h00, hi), lo);
  endfunction

  // Degrees Celsius, truncated toward zero and clamped to the 8-bit range
  function automatic logic signed [7:0] celsius_of(input logic [15:0] raw);
    longint scaled;
    scaled = (longint'(raw) * TEMP_GAIN - TEMP_BIAS) / TEMP_DIV;
    if (scaled > sftd_pkg::TEMP_MAX) return sftd_pkg::TEMP_MAX;
    if (scaled < sftd_pkg::TEMP_MIN) return sftd_pkg::TEMP_MIN;
    return scaled[7:0];
  endfunction

  // Advance the mirrored frame state by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [1:0] slot;
    reading_t   r;
    slot = st ? sftd_pkg::POS_HIGH : frame_pos;
    if (slot == sftd_pkg::POS_CRC) begin
      r.raw        = {frame_high, frame_low & sftd_pkg::LOW_DATA_MASK};
      r.status_err = frame_low[sftd_pkg::STATUS_BIT];
      r.temp       = r.status_err ? sftd_pkg::TEMP_MIN : celsius_of(r.raw);
      r.crc_err    = !r.status_err && (frame_crc != b);
      pending_readings.push_back(r);
      frame_pos = sftd_pkg::POS_HIGH;
      frame_crc = 8'h00;
    end else if (slot == sftd_pkg::POS_LOW) begin
      frame_low = b;
      frame_crc = crc8_next(frame_crc, b);
      frame_pos = sftd_pkg::POS_CRC;
    end else begin
      // position 3 cannot arise; anything else starts a frame
      frame_high = b;
      frame_crc  = crc8_next(8'h00, b);
      frame_pos  = sftd_pkg::POS_LOW;
    end
  endtask

  // Offer one item, with an optional idle burst in front of it
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    if (src_idle_en && ($urandom_range(0, 4) == 0)) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, st);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo,
                            input logic [7:0] ck, input logic st);
    send_byte(hi, st);
    send_byte(lo, 1'b0);
    send_byte(ck, 1'b0);
  endtask

  // Raw extremes, masked low bits and the rounding edges of the conversion
  task automatic test_extremes();
    send_frame(8'h00, 8'h01, frame_checksum(8'h00, 8'h01), 1'b1);
    send_frame(8'hFF, 8'hFC, frame_checksum(8'hFF, 8'hFC), 1'b1);
    // -1 C on one side, truncated to 0 C on the other
    send_frame(8'h42, 8'hCD, frame_checksum(8'h42, 8'hCD), 1'b1);
  endtask

  // Status bit set: fixed temperature, checksum ignored even when wrong
  task automatic test_status_error();
    send_frame(8'hFF, 8'hFF, 8'h00, 1'b1);
  endtask

  task automatic test_crc_mismatch();
    send_frame(8'h66, 8'h6C, ~frame_checksum(8'h66, 8'h6C), 1'b1);
  endtask

  // frame_start mid-frame drops the partial frame
  task automatic test_restart_mid_frame();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_frame(8'hFE, 8'hBC, frame_checksum(8'hFE, 8'hBC), 1'b1);
  endtask

  // After a complete frame the next one may begin without frame_start
  task automatic test_frame_without_start();
    send_frame(8'h44, 8'h40, frame_checksum(8'h44, 8'h40), 1'b0);
  endtask

  // Mostly well-formed frames, some cut short, some stray bytes
  task automatic test_random_frames(input int n_items, input bit allow_idle);
    int         first;
    int         kind;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] ck;
    first        = items_sent;
    src_idle_en  = allow_idle;
    sink_idle_en = allow_idle;
    while (items_sent - first < n_items) begin
      if (allow_idle && ($urandom_range(0, 15) == 0)) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 7))
        0:       hi = 8'h00;
        1:       hi = 8'hFF;
        2:       hi = 8'($urandom_range(8'h41, 8'h45));
        3:       hi = 8'hFE;
        default: hi = 8'($urandom_range(0, 255));
      endcase
      lo = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) lo[sftd_pkg::STATUS_BIT] = 1'b0;
      ck = ($urandom_range(0, 3) != 0) ? frame_checksum(hi, lo) : 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 15);
      if (kind < 12) begin
        send_frame(hi, lo, ck, 1'($urandom_range(0, 1)));
      end else if (kind < 14) begin
        send_byte(hi, 1'b1);
        if ($urandom_range(0, 1)) send_byte(lo, 1'b0);
        send_frame(lo, hi, frame_checksum(lo, hi), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result check and random sink stalls
  always @(posedge clk_i) begin
    reading_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no expectation: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        if ($signed(m_axis_tdata[7:0]) != want.temp) begin
          $error("temperature: expected %0d, actual %0d", want.temp,
                 $signed(m_axis_tdata[7:0]));
          errors++;
        end
        if (m_axis_tdata[23:8] != want.raw) begin
          $error("raw_reading: expected %h, actual %h", want.raw, m_axis_tdata[23:8]);
          errors++;
        end
        if (m_axis_tuser[0] != want.status_err) begin
          $error("status_error: expected %b, actual %b", want.status_err, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] != want.crc_err) begin
          $error("crc_error: expected %b, actual %b", want.crc_err, m_axis_tuser[1]);
          errors++;
        end
      end
    end
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else if (sink_idle_en && ($urandom_range(0, 5) == 0)) begin
      m_axis_tready <= 1'b0;
      sink_stall = $urandom_range(1, 6) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_status_error();
    test_crc_mismatch();
    test_restart_mid_frame();
    test_frame_without_start();
    test_random_frames(600, 1'b1);
    test_random_frames(150, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sftd_pkg.sv
rtl/sftd_temp_conv.sv
rtl/sensor_frame_temperature_decoder.sv
rtl/sftd_checker.sv
verif/sensor_frame_temperature_decoder_tb.sv
